@@ src/line_follower_pd_steering_defines.svh @@
// ----------------------------------------------------------------------------
// Line follower PD steering: assertion macros
// Shared concurrent assertion shorthands, clocked on clk, disabled in reset.
// ----------------------------------------------------------------------------
`ifndef LINE_FOLLOWER_PD_STEERING_DEFINES_SVH
`define LINE_FOLLOWER_PD_STEERING_DEFINES_SVH

// Same-cycle implication.
`define LFPD_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define LFPD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ src/lfpd_pkg.sv @@
// ----------------------------------------------------------------------------
// lfpd_pkg
// Widths, register map, lane weights and shared types for the steering block.
// ----------------------------------------------------------------------------
package lfpd_pkg;

  localparam int NUM_LANES  = 5;
  localparam int SAMPLE_W   = 10;
  localparam int TERM_W     = 12;  // sample times weight in -2..2
  localparam int WSUM_W     = 13;  // weighted sum, +-3069
  localparam int SSUM_W     = 13;  // sample sum, 0..5115
  localparam int SCALED_W   = 19;  // weighted sum times scale, +-193347
  localparam int DIVIDEND_W = 18;
  localparam int DIV_CNT_W  = 5;
  localparam int ERR_W      = 8;
  localparam int DIFF_W     = 9;
  localparam int PMUL_W     = 16;
  localparam int PD_SUM_W   = 18;
  localparam int PD_MAG_W   = 17;
  localparam int DRIVE_W    = 15;
  localparam int DMAG_W     = 14;
  localparam int DUTY_W     = 8;

  // Division by ten as multiply by reciprocal, exact for magnitudes < 2^18.
  localparam int RECIP10_W     = 16;
  localparam int RECIP10_SHIFT = 19;
  localparam int RECIP_PROD_W  = PD_MAG_W + RECIP10_W;
  localparam logic [RECIP10_W-1:0] RECIP10 = 16'd52429;

  localparam logic [DIVIDEND_W-1:0] MAX_ERR_MAG = 18'd126;

  // Register file
  localparam int THR_W   = 13;
  localparam int GAIN_W  = 8;
  localparam int SCALE_W = 6;
  localparam int PADDR_W = 5;
  localparam int PDATA_W = 32;
  localparam int REG_IDX_W = 3;

  localparam logic [REG_IDX_W-1:0] REG_SUM_THRESHOLD = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_FULL_DUTY     = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_PROP_GAIN     = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_DERIV_GAIN    = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_ERROR_SCALE   = 3'd4;

  localparam logic [THR_W-1:0]   RST_SUM_THRESHOLD = 13'd300;
  localparam logic [DUTY_W-1:0]  RST_FULL_DUTY     = 8'd153;
  localparam logic [GAIN_W-1:0]  RST_PROP_GAIN     = 8'd40;
  localparam logic [GAIN_W-1:0]  RST_DERIV_GAIN    = 8'd20;
  localparam logic [SCALE_W-1:0] RST_ERROR_SCALE   = 6'd30;

  // Lane weights, far left to far right.
  localparam logic signed [2:0] LANE_WEIGHT [NUM_LANES] =
    '{-3'sd2, -3'sd1, 3'sd0, 3'sd1, 3'sd2};

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

@@ src/lfpd_in_if.sv @@
// ----------------------------------------------------------------------------
// lfpd_in_if
// Sample channel: five sensor samples with valid/ready.
// ----------------------------------------------------------------------------
interface lfpd_in_if import lfpd_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [SAMPLE_W-1:0] sample_far_left;
  logic [SAMPLE_W-1:0] sample_left;
  logic [SAMPLE_W-1:0] sample_center;
  logic [SAMPLE_W-1:0] sample_right;
  logic [SAMPLE_W-1:0] sample_far_right;

  modport source (
    output valid, sample_far_left, sample_left, sample_center, sample_right,
           sample_far_right,
    input  ready
  );
  modport sink (
    input  valid, sample_far_left, sample_left, sample_center, sample_right,
           sample_far_right,
    output ready
  );
endinterface

@@ src/lfpd_out_if.sv @@
// ----------------------------------------------------------------------------
// lfpd_out_if
// Result channel: wheel duties, line error and drive with valid/ready.
// ----------------------------------------------------------------------------
interface lfpd_out_if import lfpd_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic [DUTY_W-1:0]         left_duty;
  logic [DUTY_W-1:0]         right_duty;
  logic signed [ERR_W-1:0]   line_error;
  logic signed [DRIVE_W-1:0] drive;

  modport source (
    output valid, left_duty, right_duty, line_error, drive,
    input  ready
  );
  modport sink (
    input  valid, left_duty, right_duty, line_error, drive,
    output ready
  );
endinterface

@@ src/line_follower_pd_steering.sv @@
// ----------------------------------------------------------------------------
// line_follower_pd_steering
// One item in flight at a time: the input is ready only while the sequencer
// is idle. A line reading that passes the threshold goes through the serial
// divider; otherwise the previous error is held. The result register frees
// the input while a result waits, unless an older result still waits there.
// Reset (rst_n, synchronous): FSM idle, result empty, previous error zero,
// configuration registers back to their power-on values.
// ----------------------------------------------------------------------------
`include "line_follower_pd_steering_defines.svh"

module line_follower_pd_steering import lfpd_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  lfpd_in_if.sink            in_if,
  lfpd_out_if.source         out_if,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready
);

  // --------------------------------------------------------------------------
  // Configuration registers (APB, zero wait state)
  // --------------------------------------------------------------------------
  logic [THR_W-1:0]     thr_r;
  logic [DUTY_W-1:0]    full_r;
  logic [GAIN_W-1:0]    kp_r;
  logic [GAIN_W-1:0]    kd_r;
  logic [SCALE_W-1:0]   scale_r;
  logic                 cfg_wr;
  logic [REG_IDX_W-1:0] cfg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel & penable & pwrite & pready;
  assign cfg_idx = paddr[PADDR_W-1:2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r   <= RST_SUM_THRESHOLD;
      full_r  <= RST_FULL_DUTY;
      kp_r    <= RST_PROP_GAIN;
      kd_r    <= RST_DERIV_GAIN;
      scale_r <= RST_ERROR_SCALE;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_SUM_THRESHOLD: thr_r   <= pwdata[THR_W-1:0];
        REG_FULL_DUTY:     full_r  <= pwdata[DUTY_W-1:0];
        REG_PROP_GAIN:     kp_r    <= pwdata[GAIN_W-1:0];
        REG_DERIV_GAIN:    kd_r    <= pwdata[GAIN_W-1:0];
        REG_ERROR_SCALE:   scale_r <= pwdata[SCALE_W-1:0];
        default:           ;  // unmapped: write ignored
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_SUM_THRESHOLD: prdata = PDATA_W'(thr_r);
      REG_FULL_DUTY:     prdata = PDATA_W'(full_r);
      REG_PROP_GAIN:     prdata = PDATA_W'(kp_r);
      REG_DERIV_GAIN:    prdata = PDATA_W'(kd_r);
      REG_ERROR_SCALE:   prdata = PDATA_W'(scale_r);
      default:           prdata = '0;
    endcase
  end

  // --------------------------------------------------------------------------
  // Sequencer
  // IDLE -> MERGE -> SCALE -> START -> (DIV) -> PD_MUL -> PD_SUM -> PD_MAP
  //      -> HOLD -> IDLE. START skips DIV when the reading is weak.
  // --------------------------------------------------------------------------
  typedef enum logic [3:0] {
    S_IDLE, S_MERGE, S_SCALE, S_START, S_DIV,
    S_PD_MUL, S_PD_SUM, S_PD_MAP, S_HOLD
  } state_t;

  state_t state_r;
  logic   in_acc;
  logic   out_acc;

  assign in_if.ready = (state_r == S_IDLE);
  assign in_acc      = in_if.valid & in_if.ready;
  assign out_acc     = out_if.valid & out_if.ready;

  // --------------------------------------------------------------------------
  // Sensor lanes: each lane weights its own sample, loaded on the transaction
  // --------------------------------------------------------------------------
  logic [SAMPLE_W-1:0]      lane_in   [NUM_LANES];
  logic [SAMPLE_W-1:0]      lane_samp [NUM_LANES];
  logic signed [TERM_W-1:0] lane_term [NUM_LANES];

  assign lane_in[0] = in_if.sample_far_left;
  assign lane_in[1] = in_if.sample_left;
  assign lane_in[2] = in_if.sample_center;
  assign lane_in[3] = in_if.sample_right;
  assign lane_in[4] = in_if.sample_far_right;

  for (genvar g = 0; g < NUM_LANES; g++) begin : g_lane
    lfpd_lane u_lane (
      .clk      (clk),
      .load     (in_acc),
      .sample   (lane_in[g]),
      .weight   (LANE_WEIGHT[g]),
      .sample_r (lane_samp[g]),
      .term_r   (lane_term[g])
    );
  end

  // Merge: sample sum and weighted sum across lanes.
  logic [SSUM_W-1:0]        ssum_nxt;
  logic signed [WSUM_W-1:0] wsum_nxt;

  always_comb begin
    ssum_nxt = '0;
    wsum_nxt = '0;
    for (int i = 0; i < NUM_LANES; i++) begin
      ssum_nxt = ssum_nxt + SSUM_W'(lane_samp[i]);
      wsum_nxt = wsum_nxt + WSUM_W'(lane_term[i]);
    end
  end

  // --------------------------------------------------------------------------
  // Datapath registers and the logic between them
  // --------------------------------------------------------------------------
  logic [SSUM_W-1:0]          ssum_r;
  logic signed [WSUM_W-1:0]   wsum_r;
  logic signed [SCALED_W-1:0] scaled_r;
  logic                       ok_r;
  logic                       neg_r;
  logic signed [ERR_W-1:0]    err_r;
  logic signed [ERR_W-1:0]    prev_r;
  logic signed [PMUL_W-1:0]   pmul_r;
  logic signed [PD_SUM_W-1:0] dmul_r;
  logic [RECIP_PROD_W-1:0]    recip_r;
  logic                       dneg_r;
  logic [DUTY_W-1:0]          res_left_r;
  logic [DUTY_W-1:0]          res_right_r;
  logic signed [DRIVE_W-1:0]  res_drive_r;

  // Weighted sum times scale; low bits of the product are sign independent.
  logic [SCALED_W-1:0] scaled_c;
  logic                read_ok;
  assign scaled_c = SCALED_W'({{(SCALED_W-WSUM_W){wsum_r[WSUM_W-1]}}, wsum_r}
                              * {{(SCALED_W-SCALE_W){1'b0}}, scale_r});
  assign read_ok  = (ssum_r != '0) && (ssum_r >= thr_r);

  // Divider on magnitudes; sign restored after, giving truncation to zero.
  div_stat_t             div_stat;
  logic                  div_start;
  logic [DIVIDEND_W-1:0] div_dvd;
  logic [DIVIDEND_W-1:0] div_quo;
  logic [ERR_W-1:0]      quo_err;

  assign div_start = (state_r == S_START) && ok_r;
  assign div_dvd   = scaled_r[SCALED_W-1] ? DIVIDEND_W'(-scaled_r)
                                          : DIVIDEND_W'(scaled_r);
  assign quo_err   = div_quo[ERR_W-1:0];

  lfpd_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dvd),
    .divisor  (ssum_r),
    .stat     (div_stat),
    .quotient (div_quo)
  );

  // PD products: kp*e and kd*(e - previous).
  logic signed [DIFF_W-1:0]   diff_c;
  logic signed [PMUL_W-1:0]   pmul_c;
  logic signed [PD_SUM_W-1:0] dmul_c;
  assign diff_c = DIFF_W'(err_r) - DIFF_W'(prev_r);
  assign pmul_c = $signed({1'b0, kp_r}) * err_r;
  assign dmul_c = $signed({1'b0, kd_r}) * diff_c;

  // PD sum, magnitude, then times the reciprocal of ten.
  logic signed [PD_SUM_W-1:0] pdsum_c;
  logic [PD_MAG_W-1:0]        pdmag_c;
  logic [RECIP_PROD_W-1:0]    recip_c;
  assign pdsum_c = PD_SUM_W'(pmul_r) + dmul_r;
  assign pdmag_c = pdsum_c[PD_SUM_W-1] ? PD_MAG_W'(-pdsum_c)
                                       : pdsum_c[PD_MAG_W-1:0];
  assign recip_c = RECIP_PROD_W'(pdmag_c) * RECIP_PROD_W'(RECIP10);

  // Wheel mapping: the slowed wheel is full minus |drive|, clamped at zero.
  logic [DMAG_W-1:0]  dmag_c;
  logic [DRIVE_W-1:0] drive_c;
  logic [DUTY_W-1:0]  slow_c;
  assign dmag_c  = recip_r[RECIP_PROD_W-1:RECIP10_SHIFT];
  assign drive_c = dneg_r ? DRIVE_W'(-{1'b0, dmag_c}) : DRIVE_W'(dmag_c);
  assign slow_c  = (dmag_c >= DMAG_W'(full_r)) ? '0 : (full_r - dmag_c[DUTY_W-1:0]);

  // --------------------------------------------------------------------------
  // Result register: frees the sequencer while the result waits downstream
  // --------------------------------------------------------------------------
  logic                      out_valid_r;
  logic [DUTY_W-1:0]         out_left_r;
  logic [DUTY_W-1:0]         out_right_r;
  logic signed [ERR_W-1:0]   out_err_r;
  logic signed [DRIVE_W-1:0] out_drive_r;
  logic                      out_load;

  assign out_load = (state_r == S_HOLD) && (!out_valid_r || out_if.ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      prev_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_acc) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (in_acc) begin
            state_r <= S_MERGE;
          end
        end
        S_MERGE: begin
          ssum_r  <= ssum_nxt;
          wsum_r  <= wsum_nxt;
          state_r <= S_SCALE;
        end
        S_SCALE: begin
          scaled_r <= scaled_c;
          ok_r     <= read_ok;
          state_r  <= S_START;
        end
        S_START: begin
          neg_r <= scaled_r[SCALED_W-1];
          if (ok_r) begin
            state_r <= S_DIV;
          end else begin
            err_r   <= prev_r;  // weak or empty reading holds the error
            state_r <= S_PD_MUL;
          end
        end
        S_DIV: begin
          if (div_stat.done) begin
            err_r   <= neg_r ? -quo_err : quo_err;
            state_r <= S_PD_MUL;
          end
        end
        S_PD_MUL: begin
          pmul_r  <= pmul_c;
          dmul_r  <= dmul_c;
          prev_r  <= err_r;
          state_r <= S_PD_SUM;
        end
        S_PD_SUM: begin
          recip_r <= recip_c;
          dneg_r  <= pdsum_c[PD_SUM_W-1];
          state_r <= S_PD_MAP;
        end
        S_PD_MAP: begin
          res_drive_r <= drive_c;
          res_left_r  <= dneg_r ? slow_c : full_r;
          res_right_r <= dneg_r ? full_r : slow_c;
          state_r     <= S_HOLD;
        end
        S_HOLD: begin
          if (out_load) begin
            out_left_r  <= res_left_r;
            out_right_r <= res_right_r;
            out_err_r   <= err_r;
            out_drive_r <= res_drive_r;
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_if.valid      = out_valid_r;
  assign out_if.left_duty  = out_left_r;
  assign out_if.right_duty = out_right_r;
  assign out_if.line_error = out_err_r;
  assign out_if.drive      = out_drive_r;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  `LFPD_ASSERT_NEXT(a_weak_holds_err, (state_r == S_START) && !ok_r, err_r == $past(prev_r), "weak reading did not hold the previous error")
  `LFPD_ASSERT_IMPL(a_div_in_div_state, div_stat.busy, state_r == S_DIV, "divider busy outside the divide state")
  `LFPD_ASSERT_IMPL(a_quot_in_range, div_stat.done, div_quo <= MAX_ERR_MAG, "centroid quotient exceeds error range")

endmodule

@@ src/lfpd_lane.sv @@
// ----------------------------------------------------------------------------
// lfpd_lane
// One sensor lane: captures its sample and the sample times the lane weight.
// ----------------------------------------------------------------------------
module lfpd_lane import lfpd_pkg::*; (
  input  logic                     clk,
  input  logic                     load,
  input  logic [SAMPLE_W-1:0]      sample,
  input  logic signed [2:0]        weight,
  output logic [SAMPLE_W-1:0]      sample_r,
  output logic signed [TERM_W-1:0] term_r
);

  logic [TERM_W-1:0] mag1;
  logic [TERM_W-1:0] mag2;
  logic [TERM_W-1:0] term_nxt;

  assign mag1 = TERM_W'(sample);
  assign mag2 = TERM_W'({sample, 1'b0});

  always_comb begin
    case (weight)
      -3'sd2:  term_nxt = -mag2;
      -3'sd1:  term_nxt = -mag1;
      3'sd1:   term_nxt = mag1;
      3'sd2:   term_nxt = mag2;
      default: term_nxt = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (load) begin
      sample_r <= sample;
      term_r   <= term_nxt;
    end
  end

endmodule

@@ src/lfpd_div.sv @@
// ----------------------------------------------------------------------------
// lfpd_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module lfpd_div import lfpd_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  input  logic [DIVIDEND_W-1:0] dividend,
  input  logic [SSUM_W-1:0]     divisor,
  output div_stat_t             stat,
  output logic [DIVIDEND_W-1:0] quotient
);

  logic [DIVIDEND_W-1:0] quo_r;
  logic [SSUM_W-1:0]     rem_r;
  logic [SSUM_W-1:0]     dvs_r;
  logic [DIV_CNT_W-1:0]  cnt_r;
  logic                  busy_r;
  logic                  done_r;
  logic [SSUM_W:0]       rem_sh;
  logic                  qbit;
  logic [SSUM_W-1:0]     rem_nxt;

  assign rem_sh  = {rem_r, quo_r[DIVIDEND_W-1]};
  assign qbit    = (rem_sh >= {1'b0, dvs_r});
  assign rem_nxt = qbit ? SSUM_W'(rem_sh - {1'b0, dvs_r}) : rem_sh[SSUM_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= DIV_CNT_W'(DIVIDEND_W - 1);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == '0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= dividend;
      rem_r <= '0;
      dvs_r <= divisor;
    end else if (busy_r) begin
      quo_r <= {quo_r[DIVIDEND_W-2:0], qbit};
      rem_r <= rem_nxt;
    end
  end

  assign stat.busy = busy_r;
  assign stat.done = done_r;
  assign quotient  = quo_r;

endmodule
